@@ src/mscg_pkg.sv @@
// ----------------------------------------------------------------------------
// mscg_pkg: shared types and constants of the color gradient
// Field widths, stop word layout, register indexes and divider sizing.
// ----------------------------------------------------------------------------
package mscg_pkg;

    localparam int POS_W         = 16;
    localparam int STOP_POS_W    = 15;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 3;
    localparam int STOP_W        = STOP_POS_W + NUM_CHAN * CHAN_W;
    localparam int STOP_CNT_W    = 3;
    localparam int NUM_STOP_REGS = 6;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = STOP_W;

    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST  = 4'd2;

    localparam logic [STOP_CNT_W-1:0] MIN_STOPS = 3'd2;
    localparam logic [STOP_POS_W-1:0] FULL_SCALE = 15'd25600;

    // numerator of the interpolation: color times position span
    localparam int NUM_W      = CHAN_W + STOP_POS_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = CHAN_W / DIV_BITS;
    localparam int QUO_MSB    = CHAN_W - 1;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_STAIRS = 1'b1
    } interp_mode_t;

    typedef logic [STOP_W-1:0]     stop_word_t;
    typedef logic [STOP_POS_W-1:0] spos_t;
    typedef logic [CHAN_W-1:0]     chan_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef chan_t [NUM_CHAN-1:0]  rgb_t;

    typedef struct packed {
        num_t [NUM_CHAN-1:0] num;
        spos_t               den;
    } div_req_t;

    localparam stop_word_t STOP1_RESET = 39'h00_00FF_FFFF;
    localparam stop_word_t STOP2_RESET = {FULL_SCALE, 24'h00_0000};

    function automatic spos_t stop_pos(input stop_word_t w);
        return w[STOP_W-1 -: STOP_POS_W];
    endfunction

    // channel 0 is red, in the top byte of the color field
    function automatic chan_t stop_chan(input stop_word_t w, input int ch);
        return w[(NUM_CHAN - 1 - ch) * CHAN_W +: CHAN_W];
    endfunction

endpackage

@@ src/mscg_pos_if.sv @@
// ----------------------------------------------------------------------------
// mscg_pos_if: position channel
// Valid/ready channel that carries one gradient position per transaction.
// ----------------------------------------------------------------------------
interface mscg_pos_if;
    import mscg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] grad_pos;

    modport source (output valid, output grad_pos, input ready);
    modport sink   (input valid, input grad_pos, output ready);
endinterface

@@ src/mscg_rgb_if.sv @@
// ----------------------------------------------------------------------------
// mscg_rgb_if: color channel
// Valid/ready channel that carries one RGB color per transaction.
// ----------------------------------------------------------------------------
interface mscg_rgb_if;
    import mscg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

@@ src/mscg_div.sv @@
// ----------------------------------------------------------------------------
// mscg_div: pipelined three-channel divider
// Restoring division, DIV_BITS quotient bits per stage, 8-bit quotient.
// ----------------------------------------------------------------------------
module mscg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mscg_pkg::div_req_t req,
    output logic               out_valid,
    input  logic               out_ready,
    output mscg_pkg::rgb_t     quo
);
    import mscg_pkg::*;

    logic                vld_reg [DIV_STAGES];
    num_t [NUM_CHAN-1:0] rem_reg [DIV_STAGES];
    rgb_t                quo_reg [DIV_STAGES];
    spos_t               den_reg [DIV_STAGES];
    wire [DIV_STAGES:0]  rdy;

    assign rdy[DIV_STAGES] = out_ready;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic                src_vld;
        num_t [NUM_CHAN-1:0] src_rem;
        rgb_t                src_quo;
        spos_t               src_den;
        num_t [NUM_CHAN-1:0] rem_next;
        rgb_t                quo_next;

        if (s == 0) begin : g_first
            assign src_vld = in_valid;
            assign src_rem = req.num;
            assign src_quo = '0;
            assign src_den = req.den;
        end else begin : g_rest
            assign src_vld = vld_reg[s-1];
            assign src_rem = rem_reg[s-1];
            assign src_quo = quo_reg[s-1];
            assign src_den = den_reg[s-1];
        end

        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        // subtract the shifted divisor where it fits, one quotient bit per step
        always_comb
        begin
            logic [NUM_W:0] trial;
            rem_next = src_rem;
            quo_next = src_quo;
            trial    = '0;
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                for (int j = 0; j < DIV_BITS; j++)
                begin
                    trial = (NUM_W + 1)'(src_den) << (QUO_MSB - s * DIV_BITS - j);
                    if ({1'b0, rem_next[ch]} >= trial)
                    begin
                        rem_next[ch] = rem_next[ch] - trial[NUM_W-1:0];
                        quo_next[ch][QUO_MSB - s * DIV_BITS - j] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (rdy[s])
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                den_reg[s] <= src_den;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo       = quo_reg[DIV_STAGES-1];

endmodule

@@ src/multi_stop_color_gradient.sv @@
// ----------------------------------------------------------------------------
// multi_stop_color_gradient: piecewise linear colormap over up to six stops
// Maps a signed position (1/256 percent) to an RGB color, one per clock while color.ready holds.
// ----------------------------------------------------------------------------
// Usage:
//   sample  - position channel; one transaction carries grad_pos.
//   color   - color channel; one transaction carries red/green/blue.
//   cfg_*   - register writes (mode, stop count, stop words); write only
//             while no position is in flight.
// Throughput: one position per cycle while color.ready holds. Path: sample
//   to color.valid runs through eight register stages, the first loaded at the
//   accepting edge on sample: the four front stages (capture, stop search,
//   span setup, multiply) plus the four-stage divider that retires two
//   quotient bits per stage.
// Stall: every stage holds its own valid bit; a stage that holds data and
//   cannot pass it on stalls, empty stages keep filling, so sample.ready
//   stays high until the whole pipe is full behind a stalled color channel.
// Reset: all valid bits clear, mode is linear, two stops from white at 0 to
//   black at 100 percent.
// ----------------------------------------------------------------------------
module multi_stop_color_gradient #(
    parameter int MAX_STOPS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mscg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mscg_pkg::CFG_DATA_W-1:0] cfg_data,
    mscg_pos_if.sink                        sample,
    mscg_rgb_if.source                      color
);
    import mscg_pkg::*;

    localparam int IDX_W = $clog2(MAX_STOPS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    interp_mode_t            mode_reg;
    logic [STOP_CNT_W-1:0]   count_reg;
    stop_word_t              stop_reg [MAX_STOPS];
    logic [STOP_CNT_W-1:0]   n_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            count_reg <= MIN_STOPS;
            for (int i = 0; i < MAX_STOPS; i++)
                stop_reg[i] <= (i == 0) ? STOP1_RESET : ((i == 1) ? STOP2_RESET : '0);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INTERP_MODE: mode_reg  <= interp_mode_t'(cfg_data[0]);
                REG_STOP_COUNT:  count_reg <= cfg_data[STOP_CNT_W-1:0];
                default:
                begin
                    // stop words beyond MAX_STOPS and unknown indexes are dropped
                    for (int i = 0; i < MAX_STOPS; i++)
                        if (cfg_index == CFG_IDX_W'(int'(REG_STOP_FIRST) + i))
                            stop_reg[i] <= cfg_data;
                end
            endcase
        end
    end

    // clamp the stop count into 2..MAX_STOPS
    always_comb
    begin
        if (count_reg < MIN_STOPS)
            n_used = MIN_STOPS;
        else if (count_reg > STOP_CNT_W'(MAX_STOPS))
            n_used = STOP_CNT_W'(MAX_STOPS);
        else
            n_used = count_reg;
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the position
    // ------------------------------------------------------------------
    logic                    s1_vld_reg;
    logic signed [POS_W-1:0] s1_pos_reg;
    logic                    s1_rdy;
    logic                    s2_rdy;
    logic                    s3_rdy;
    logic                    s4_rdy;
    logic                    div_rdy;

    assign s1_rdy       = !s1_vld_reg || s2_rdy;
    assign sample.ready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (s1_rdy)
            s1_vld_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
            s1_pos_reg <= sample.grad_pos;
    end

    // ------------------------------------------------------------------
    // Stage 2: compare against every stop and pick the segment.
    // seg selects stop[seg] as the upper stop; direct means that stop's
    // color is the answer, otherwise interpolate from stop[seg-1].
    // ------------------------------------------------------------------
    logic             s2_vld_reg;
    logic [IDX_W-1:0] s2_seg_reg;
    logic             s2_direct_reg;
    spos_t            s2_up_reg;
    logic [IDX_W-1:0] seg_next;
    logic             direct_next;
    spos_t            up;

    assign s2_rdy = !s2_vld_reg || s3_rdy;
    assign up     = s1_pos_reg[STOP_POS_W-1:0];

    always_comb
    begin
        logic             is_low;
        logic             is_high;
        logic             found;
        logic             hit;
        logic [IDX_W-1:0] hi_idx;
        logic [IDX_W-1:0] stair_idx;
        logic [IDX_W-1:0] last_idx;

        is_low    = (s1_pos_reg <= 0);
        is_high   = !s1_pos_reg[POS_W-1] && (up >= FULL_SCALE);
        last_idx  = IDX_W'(n_used - 3'd1);

        // first used stop at or above the position, scanned from the top down
        found  = 1'b0;
        hit    = 1'b0;
        hi_idx = '0;
        for (int i = MAX_STOPS - 1; i >= 0; i--)
        begin
            if (i < int'(n_used) && stop_pos(stop_reg[i]) >= up)
            begin
                found  = 1'b1;
                hit    = (stop_pos(stop_reg[i]) == up);
                hi_idx = IDX_W'(i);
            end
        end

        // last used stop at or below the position
        stair_idx = '0;
        for (int i = 0; i < MAX_STOPS; i++)
            if (i < int'(n_used) && stop_pos(stop_reg[i]) <= up)
                stair_idx = IDX_W'(i);

        if (is_low)
        begin
            seg_next    = '0;
            direct_next = 1'b1;
        end
        else if (is_high)
        begin
            seg_next    = last_idx;
            direct_next = 1'b1;
        end
        else if (mode_reg == MODE_STAIRS)
        begin
            seg_next    = stair_idx;
            direct_next = 1'b1;
        end
        else if (!found)
        begin
            seg_next    = last_idx;
            direct_next = 1'b1;
        end
        else
        begin
            // an exact hit or a position below the first stop takes its color
            seg_next    = hi_idx;
            direct_next = hit || (hi_idx == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (s2_rdy)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy)
        begin
            s2_seg_reg    <= seg_next;
            s2_direct_reg <= direct_next;
            s2_up_reg     <= up;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: fetch the stop pair and form the two spans.
    // A direct color becomes c0 over a span of one, so the divider
    // passes it through unchanged.
    // ------------------------------------------------------------------
    logic [2*STOP_W-1:0] seg_pair [MAX_STOPS];
    logic [2*STOP_W-1:0] pair_sel;
    stop_word_t          lo_word;
    stop_word_t          hi_word;
    logic                s3_vld_reg;
    rgb_t                s3_c0_reg;
    rgb_t                s3_c1_reg;
    spos_t               s3_d0_reg;
    spos_t               s3_d1_reg;
    rgb_t                c0_next;
    rgb_t                c1_next;
    spos_t               d0_next;
    spos_t               d1_next;

    for (genvar i = 0; i < MAX_STOPS; i++) begin : g_pair
        assign seg_pair[i] = {stop_reg[(i == 0) ? 0 : i - 1], stop_reg[i]};
    end

    assign s3_rdy   = !s3_vld_reg || s4_rdy;
    assign pair_sel = seg_pair[s2_seg_reg];
    assign lo_word  = pair_sel[2*STOP_W-1:STOP_W];
    assign hi_word  = pair_sel[STOP_W-1:0];

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            c1_next[ch] = stop_chan(hi_word, ch);
            c0_next[ch] = s2_direct_reg ? stop_chan(hi_word, ch) : stop_chan(lo_word, ch);
        end
        if (s2_direct_reg)
        begin
            d1_next = spos_t'(1);
            d0_next = '0;
        end
        else
        begin
            d1_next = stop_pos(hi_word) - s2_up_reg;
            d0_next = s2_up_reg - stop_pos(lo_word);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (s3_rdy)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy)
        begin
            s3_c0_reg <= c0_next;
            s3_c1_reg <= c1_next;
            s3_d0_reg <= d0_next;
            s3_d1_reg <= d1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: weighted sum c0*(p1-p) + c1*(p-p0) over span p1-p0
    // ------------------------------------------------------------------
    logic                  s4_vld_reg;
    div_req_t              s4_req_reg;
    div_req_t              req_next;
    logic [STOP_POS_W:0]   span;
    rgb_t                  quo;

    assign s4_rdy = !s4_vld_reg || div_rdy;
    assign span   = {1'b0, s3_d0_reg} + {1'b0, s3_d1_reg};

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
            req_next.num[ch] = num_t'(s3_c0_reg[ch]) * num_t'(s3_d1_reg)
                             + num_t'(s3_c1_reg[ch]) * num_t'(s3_d0_reg);
        req_next.den = span[STOP_POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (s4_rdy)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s4_rdy)
            s4_req_reg <= req_next;
    end

    // ------------------------------------------------------------------
    // Stages 5 to 8: divide; the last divider stage is the output register
    // ------------------------------------------------------------------
    mscg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_vld_reg),
        .in_ready  (div_rdy),
        .req       (s4_req_reg),
        .out_valid (color.valid),
        .out_ready (color.ready),
        .quo       (quo)
    );

    assign color.red_out   = quo[0];
    assign color.green_out = quo[1];
    assign color.blue_out  = quo[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s2_rdy |=> s1_vld_reg && $stable(s1_pos_reg))
        else $error("stage 1 lost or changed a stalled position");

    a_seg_used: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (STOP_CNT_W'(s2_seg_reg) < n_used))
        else $error("selected stop is not in use");

    a_interp_pred: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg && !s2_direct_reg |-> s2_seg_reg != '0)
        else $error("interpolation without a lower stop");

    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |-> span != '0)
        else $error("zero interpolation span");

    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (s4_req_reg.num[0] >> CHAN_W) < num_t'(s4_req_reg.den))
        else $error("red quotient would not fit in a channel");

endmodule
